// ----- rtl/frame_slot_table_with_eviction_defines.svh -----
// Assertion macros used by the frame slot table datapath.
`ifndef FRAME_SLOT_TABLE_WITH_EVICTION_DEFINES_SVH
`define FRAME_SLOT_TABLE_WITH_EVICTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FSTE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FSTE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/fste_pkg.sv -----
// Shared widths, codes and control structs of the frame slot table.
`default_nettype none

package fste_pkg;

   // field widths
   localparam int CMD_W      = 3;
   localparam int SLOT_NUM_W = 4;
   localparam int BOOK_W     = 6;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 3;
   localparam int SIU_W      = 4;
   localparam int BCNT_W     = 7;
   localparam int DIST_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_STORE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INVAL   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_VICTIM  = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd2;

   // register index codes (address bit 2)
   localparam logic REG_SLOTS_IN_USE = 1'b0;
   localparam logic REG_BOOK_COUNT   = 1'b1;

   // one request item
   typedef struct packed {
      logic [CMD_W-1:0]      command;
      logic [SLOT_NUM_W-1:0] slot_number;
      logic [BOOK_W-1:0]     book_number;
      logic [BOOK_W-1:0]     center_book;
      logic                  protect_valid;
      logic [BOOK_W-1:0]     protect_book;
   } fste_req_type;

   // decoded register write
   typedef struct packed {
      logic                  write;
      logic                  index;
      logic [CSR_DATA_W-1:0] wdata;
   } fste_csr_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic a_step;
      logic b_step;
      logic load_out;
   } fste_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_W-1:0] code;
      logic             a_hit;
      logic             last;
      logic             out_free;
   } fste_stat_type;

endpackage

`default_nettype wire

// ----- rtl/fste_if.sv -----
// Request and response channel interfaces of the frame slot table.
`default_nettype none

interface fste_req_if import fste_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      command;
   logic [SLOT_NUM_W-1:0] slot_number;
   logic [BOOK_W-1:0]     book_number;
   logic [BOOK_W-1:0]     center_book;
   logic                  protect_valid;
   logic [BOOK_W-1:0]     protect_book;

   modport source (output valid, command, slot_number, book_number, center_book,
                   protect_valid, protect_book, input ready);
   modport sink   (input valid, command, slot_number, book_number, center_book,
                   protect_valid, protect_book, output ready);
endinterface

interface fste_rsp_if import fste_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [SLOT_OUT_W-1:0] slot_out;

   modport source (output valid, status, slot_out, input ready);
   modport sink   (input valid, status, slot_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/fste_ctrl.sv -----
// Sequencer of the frame slot table: decode, slot scans and result hand-off.
`default_nettype none

module fste_ctrl import fste_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire fste_stat_type stat,
   output logic               req_ready,
   output fste_cmd_type       cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_SCAN_A = 3'd2;
   localparam logic [2:0] ST_SCAN_B = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            unique case (stat.code) inside
               CMD_LOOKUP, CMD_VICTIM: state_in = ST_SCAN_A;
               default:                state_in = ST_DONE;
            endcase
         end
         // first pass: lookup match or first free slot
         ST_SCAN_A: begin
            cmd.a_step = 1'b1;
            if (stat.a_hit) begin
               state_in = ST_DONE;
            end else if (stat.last) begin
               state_in = (stat.code == CMD_VICTIM) ? ST_SCAN_B : ST_DONE;
            end
         end
         // second pass: farthest book
         ST_SCAN_B: begin
            cmd.b_step = 1'b1;
            if (stat.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/fste_dpath.sv -----
// Slot table, registers, scan unit and response register of the frame slot table.
`default_nettype none

module fste_dpath import fste_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fste_req_type          req,
   input  wire fste_csr_type          csr,
   input  wire fste_cmd_type          cmd,
   input  wire logic                  rsp_ready,
   output fste_stat_type              stat,
   output logic [CSR_DATA_W-1:0]      csr_rdata,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [SLOT_OUT_W-1:0]      rsp_slot
);

`include "frame_slot_table_with_eviction_defines.svh"

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   logic [SLOTS-1:0]       valid_ff, valid_in;
   logic [BOOK_W-1:0]      book_ff [SLOTS];
   logic [BOOK_W-1:0]      book_in [SLOTS];
   logic [SIU_W-1:0]       siu_ff, siu_in;
   logic [BCNT_W-1:0]      bcnt_ff, bcnt_in;
   fste_req_type           req_ff, req_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic signed [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]       best_slot_ff, best_slot_in;
   logic                   found_ff, found_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [SLOT_OUT_W-1:0]  res_slot_ff, res_slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;

   logic [IDX_W-1:0]       slot_idx;
   logic                   store_reject;
   logic                   release_reject;
   logic [BOOK_W-1:0]      scan_book;
   logic                   scan_valid;
   logic                   last;
   logic                   a_hit;
   logic [BOOK_W-1:0]      diff;
   logic signed [DIST_W-1:0] diff_s, alt, ring_dist;
   logic                   cand;

   // slot under scan and its distance from the centre
   always_comb begin
      scan_book  = book_ff[idx_ff];
      scan_valid = valid_ff[idx_ff];
      last       = (idx_ff == LAST_IDX);
      if (req_ff.command == CMD_LOOKUP) begin
         a_hit = scan_valid && (scan_book == req_ff.book_number);
      end else begin
         a_hit = !scan_valid;
      end
      diff   = (scan_book >= req_ff.center_book) ? scan_book - req_ff.center_book
                                                 : req_ff.center_book - scan_book;
      diff_s = signed'(DIST_W'(diff));
      alt    = signed'(DIST_W'(bcnt_ff)) - diff_s;
      ring_dist = (diff_s < alt) ? diff_s : alt;
      cand   = scan_valid &&
               !(req_ff.protect_valid && (scan_book == req_ff.protect_book));
   end

   // range checks on the requested slot
   always_comb begin
      slot_idx       = IDX_W'(req_ff.slot_number);
      release_reject = (32'(req_ff.slot_number) >= SLOTS);
      store_reject   = release_reject || (req_ff.slot_number >= siu_ff);
   end

   // next-state logic
   always_comb begin
      valid_in      = valid_ff;
      book_in       = book_ff;
      siu_in        = siu_ff;
      bcnt_in       = bcnt_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      best_dist_in  = best_dist_ff;
      best_slot_in  = best_slot_ff;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;

      // register writes
      if (csr.write) begin
         if (csr.index == REG_SLOTS_IN_USE) begin
            siu_in = csr.wdata[SIU_W-1:0];
         end else begin
            bcnt_in = csr.wdata[BCNT_W-1:0];
         end
      end

      if (cmd.capture) begin
         req_in = req;
      end

      // store, release and invalidate, and scan set-up
      if (cmd.exec) begin
         res_status_in = STATUS_OK;
         res_slot_in   = '0;
         unique case (req_ff.command) inside
            CMD_STORE: begin
               if (store_reject) begin
                  res_status_in = STATUS_REJECT;
               end else begin
                  valid_in[slot_idx] = 1'b1;
                  book_in[slot_idx]  = req_ff.book_number;
               end
            end
            CMD_RELEASE: begin
               if (release_reject) begin
                  res_status_in = STATUS_REJECT;
               end else begin
                  valid_in[slot_idx] = 1'b0;
               end
            end
            CMD_INVAL: begin
               valid_in = '0;
               siu_in   = '0;
            end
            CMD_LOOKUP, CMD_VICTIM: begin
               idx_in       = '0;
               best_dist_in = '1;
               best_slot_in = '0;
               found_in     = 1'b0;
            end
            default: ;
         endcase
      end

      // first pass
      if (cmd.a_step) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
         if (a_hit) begin
            res_status_in = STATUS_OK;
            res_slot_in   = SLOT_OUT_W'(idx_ff);
         end else if (last && (req_ff.command == CMD_LOOKUP)) begin
            res_status_in = STATUS_NONE;
            res_slot_in   = '0;
         end
      end

      // second pass: first maximum wins
      if (cmd.b_step) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
         if (cand && (ring_dist > best_dist_ff)) begin
            best_dist_in = ring_dist;
            best_slot_in = idx_ff;
            found_in     = 1'b1;
         end
         if (last) begin
            res_status_in = found_in ? STATUS_OK : STATUS_NONE;
            res_slot_in   = found_in ? SLOT_OUT_W'(best_slot_in) : '0;
         end
      end

      // hand result to the output register
      if (cmd.load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_slot_in   = res_slot_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         siu_ff       <= '0;
         bcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         siu_ff       <= siu_in;
         bcnt_ff      <= bcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      book_ff       <= book_in;
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      best_dist_ff  <= best_dist_in;
      best_slot_ff  <= best_slot_in;
      found_ff      <= found_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   always_comb begin
      stat.code     = req_ff.command;
      stat.a_hit    = a_hit;
      stat.last     = last;
      stat.out_free = !rsp_valid_ff || rsp_ready;
      csr_rdata     = (csr.index == REG_BOOK_COUNT) ? CSR_DATA_W'(bcnt_ff)
                                                    : CSR_DATA_W'(siu_ff);
      rsp_valid     = rsp_valid_ff;
      rsp_status    = rsp_status_ff;
      rsp_slot      = rsp_slot_ff;
   end

   `FSTE_ASSERT_NEXT(a_inval_clears, clock, reset, cmd.exec && (req_ff.command == CMD_INVAL), (valid_ff == '0) && (siu_ff == '0), "invalidate left slots or fill limit set")
   `FSTE_ASSERT_NEXT(a_reject_stable, clock, reset, cmd.exec && (req_ff.command == CMD_STORE) && store_reject, $stable(valid_ff), "rejected store changed the valid marks")
   `FSTE_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load_out, rsp_valid_ff && (rsp_status_ff == $past(res_status_ff)), "loaded result not presented")
   `FSTE_ASSERT_NEXT(a_victim_found, clock, reset, cmd.b_step && last && found_in, res_status_ff == STATUS_OK, "victim found but status not ok")
   `FSTE_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready, "result loaded over a pending transfer")

endmodule

`default_nettype wire

// ----- rtl/frame_slot_table_with_eviction.sv -----
// Top level of the frame slot table with distance-based eviction.
//
//   channel  direction  handshake        carries
//   req      in         valid / ready    command, slot, book, centre, protect
//   rsp      out        valid / ready    status, slot_out
//   csr      in/out     APB, pready = 1  slots_in_use @0x0, book_count @0x4
//
// One item at a time. Store, release, invalidate and unused codes go from capture
// to execute to done; lookup adds a scan that stops at a match, victim choice a
// free-slot scan, then if none is free a farthest-book scan, one slot a cycle.
// Reset is synchronous; valid marks clear at once, so no clearing pass runs.
// A stalled response holds in the output register; the next request is taken
// meanwhile and its result waits until that transfer completes.
`default_nettype none

module frame_slot_table_with_eviction import fste_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   fste_req_if.sink                   req,
   fste_rsp_if.source                 rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   fste_req_type  req_data;
   fste_csr_type  csr_wr;
   fste_cmd_type  cmd;
   fste_stat_type stat;
   logic          ready;

   // request payload and register write decode
   always_comb begin
      req_data.command       = req.command;
      req_data.slot_number   = req.slot_number;
      req_data.book_number   = req.book_number;
      req_data.center_book   = req.center_book;
      req_data.protect_valid = req.protect_valid;
      req_data.protect_book  = req.protect_book;
      csr_pready   = 1'b1;
      csr_wr.write = csr_psel && csr_penable && csr_pwrite && csr_pready;
      csr_wr.index = csr_paddr[2];
      csr_wr.wdata = csr_pwdata;
      req.ready    = ready;
   end

   fste_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .stat      (stat),
      .req_ready (ready),
      .cmd       (cmd)
   );

   fste_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req        (req_data),
      .csr        (csr_wr),
      .cmd        (cmd),
      .rsp_ready  (rsp.ready),
      .stat       (stat),
      .csr_rdata  (csr_prdata),
      .rsp_valid  (rsp.valid),
      .rsp_status (rsp.status),
      .rsp_slot   (rsp.slot_out)
   );

endmodule

`default_nettype wire
